>>> hdl/three_of_six_decoder_defines.svh
// Assertion macros used by the checker of the 3-of-6 decoder.
// Each macro expects clk and rst_n in scope.
`ifndef THREE_OF_SIX_DECODER_DEFINES_SVH
`define THREE_OF_SIX_DECODER_DEFINES_SVH

// Same-cycle implication.
`define TSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tsd_pkg.sv
package tsd_pkg;

    // Beat on the coded side
    typedef struct packed {
        logic [7:0] coded_byte;
        logic       frame_start;
    } coded_beat_t;

    // Beat on the decoded side
    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       symbol_error;
    } decoded_beat_t;

    // Position of the next byte in its group of three
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } phase_t;

    localparam int SYM_W = 6;
    localparam logic [4:0] NC = 5'h10;

    // Tolerant reverse table: bit 4 set means the code has no nibble
    localparam logic [4:0] REVERSE_MAP [0:63] = '{
        NC,    NC,    NC,    5'h07, NC,    5'h01, 5'h02, 5'h02,
        NC,    5'h03, 5'h03, 5'h03, 5'h01, 5'h01, 5'h02, 5'h02,
        5'h05, 5'h05, 5'h07, 5'h07, 5'h00, 5'h00, 5'h00, 5'h00,
        5'h04, 5'h05, 5'h06, 5'h06, 5'h04, 5'h04, 5'h06, NC,
        NC,    5'h0B, 5'h0B, 5'h0B, 5'h09, 5'h09, 5'h0A, 5'h09,
        5'h08, 5'h0F, 5'h0F, 5'h0F, 5'h08, 5'h08, 5'h0A, NC,
        5'h0D, 5'h0D, 5'h0E, 5'h0E, 5'h0C, 5'h0C, 5'h0A, NC,
        5'h0D, 5'h0D, 5'h0E, NC,    5'h0C, NC,    NC,    NC
    };

    // Map two symbols to one byte, earlier symbol in the high nibble
    function automatic decoded_beat_t decode_pair(logic [SYM_W-1:0] first,
                                                  logic [SYM_W-1:0] second);
        logic [4:0]    hi;
        logic [4:0]    lo;
        decoded_beat_t r;
        hi = REVERSE_MAP[first];
        lo = REVERSE_MAP[second];
        r.decoded_byte = {(hi[4] ? 4'hF : hi[3:0]), lo[3:0]};
        r.symbol_error = hi[4] | lo[4];
        if (lo[4])
        begin
            r.decoded_byte = 8'hFF;
        end
        return r;
    endfunction

endpackage

>>> hdl/three_of_six_decoder.sv
// Tolerant 3-out-of-6 symbol decoder.
// coded channel (coded_valid/coded_ready/coded): one received byte per beat,
//   frame_start set on the first byte of a frame restarts the group of three.
// decoded channel (decoded_valid/decoded_ready/decoded): one byte per beat,
//   produced after the second and the third byte of every group; symbol_error
//   flags a symbol with no table entry (high nibble 0xF for a bad first symbol,
//   whole byte 0xFF for a bad second symbol).
// Path: the last coded beat of a pair is taken into the pair register, then
//   moves into the result register, which raises decoded_valid.
// Throughput: one coded beat per cycle while the result register is empty or
//   being taken; otherwise the stall rule below applies.
// Stall: while decoded_valid is held off by decoded_ready, the pair register
//   still takes one more beat; after that coded_ready drops until the result
//   is taken.
// Reset: rst_n clears both valid flags, the group phase and the held byte;
//   the first byte after reset starts a group.
module three_of_six_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  coded_valid,
    output logic                  coded_ready,
    input  tsd_pkg::coded_beat_t   coded,
    output logic                  decoded_valid,
    input  logic                  decoded_ready,
    output tsd_pkg::decoded_beat_t decoded
);

    // Group tracking state
    tsd_pkg::phase_t phase_reg;
    tsd_pkg::phase_t phase_next;
    logic [7:0]      held_reg;
    logic [7:0]      held_next;

    // Pair register: two symbols waiting for the table
    logic                        pair_valid_reg;
    logic                        pair_valid_next;
    logic                        pair_emit_reg;
    logic                        pair_emit_next;
    logic [tsd_pkg::SYM_W-1:0]   first_sym_reg;
    logic [tsd_pkg::SYM_W-1:0]   first_sym_next;
    logic [tsd_pkg::SYM_W-1:0]   second_sym_reg;
    logic [tsd_pkg::SYM_W-1:0]   second_sym_next;

    // Result register
    logic                   decoded_valid_reg;
    logic                   decoded_valid_next;
    tsd_pkg::decoded_beat_t decoded_reg;
    tsd_pkg::decoded_beat_t decoded_next;

    logic            advance;
    logic            take;
    tsd_pkg::phase_t eff_phase;

    // Result slot frees up when empty or being taken this cycle
    assign advance     = !decoded_valid_reg || decoded_ready;
    assign coded_ready = !pair_valid_reg || advance;
    assign take        = coded_valid && coded_ready;

    // Split the bitstream into symbol pairs on each accepted beat
    always_comb
    begin
        eff_phase       = coded.frame_start ? tsd_pkg::PH_0 : phase_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        pair_emit_next  = 1'b0;
        first_sym_next  = first_sym_reg;
        second_sym_next = second_sym_reg;
        unique case (eff_phase)
            tsd_pkg::PH_1:
            begin
                first_sym_next  = held_reg[7:2];
                second_sym_next = {held_reg[1:0], coded.coded_byte[7:4]};
                pair_emit_next  = 1'b1;
                phase_next      = tsd_pkg::PH_2;
            end
            tsd_pkg::PH_2:
            begin
                first_sym_next  = {held_reg[3:0], coded.coded_byte[7:6]};
                second_sym_next = coded.coded_byte[5:0];
                pair_emit_next  = 1'b1;
                phase_next      = tsd_pkg::PH_0;
            end
            default:
            begin
                // first byte of a group: hold it, no result
                phase_next = tsd_pkg::PH_1;
            end
        endcase
        held_next = coded.coded_byte;
        if (!take)
        begin
            phase_next      = phase_reg;
            held_next       = held_reg;
            pair_emit_next  = pair_emit_reg;
            first_sym_next  = first_sym_reg;
            second_sym_next = second_sym_reg;
        end
    end

    // Pair register loads whenever it can move on; drop pairs with no result
    assign pair_valid_next    = coded_ready ? take : pair_valid_reg;
    assign decoded_valid_next = advance ? (pair_valid_reg && pair_emit_reg)
                                        : decoded_valid_reg;
    assign decoded_next       = advance ? tsd_pkg::decode_pair(first_sym_reg, second_sym_reg)
                                        : decoded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tsd_pkg::PH_0;
            held_reg          <= '0;
            pair_valid_reg    <= 1'b0;
            decoded_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            held_reg          <= held_next;
            pair_valid_reg    <= pair_valid_next;
            decoded_valid_reg <= decoded_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        pair_emit_reg  <= pair_emit_next;
        first_sym_reg  <= first_sym_next;
        second_sym_reg <= second_sym_next;
        decoded_reg    <= decoded_next;
    end

    assign decoded_valid = decoded_valid_reg;
    assign decoded       = decoded_reg;

endmodule

>>> hdl/tsd_chk.sv
`include "three_of_six_decoder_defines.svh"

module tsd_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   coded_valid,
    input logic                   coded_ready,
    input logic                   decoded_valid,
    input logic                   decoded_ready,
    input tsd_pkg::decoded_beat_t decoded
);

    // Stalled result beat holds
    `TSD_ASSERT_NXT(a_out_hold, decoded_valid && !decoded_ready,
                    decoded_valid && $stable(decoded), "decoded beat changed under stall")

    // Any symbol error forces the high nibble to 0xF
    `TSD_ASSERT_IMP(a_err_nibble, decoded_valid && decoded.symbol_error,
                    decoded.decoded_byte[7:4] == 4'hF, "error beat without 0xF high nibble")

    // A fresh result follows a coded beat taken before it
    `TSD_ASSERT_IMP(a_out_cause, $rose(decoded_valid),
                    $past(coded_valid && coded_ready, 2), "result without a coded beat")

    // A stalled result blocks a second pending pair from entering
    `TSD_ASSERT_IMP(a_no_overrun, $past(decoded_valid && !decoded_ready)
                    && decoded_valid && !decoded_ready && $past(coded_valid && coded_ready),
                    !coded_ready, "coded beat taken while both stages are full")

endmodule

bind three_of_six_decoder tsd_chk u_tsd_chk (.*);

>>> verif/three_of_six_decoder_test.sv
`timescale 1ns / 1ps

// Symbol code to nibble, tolerant of near-miss codes.
// Bit 4 set marks a code that carries no nibble.
localparam int         MISS_BIT = 4;
localparam logic [4:0] NO_NIB   = 5'h10;
localparam logic [4:0] CODE_TO_NIBBLE [64] = '{
    NO_NIB, NO_NIB, NO_NIB, 5'h07,  NO_NIB, 5'h01,  5'h02,  5'h02,
    NO_NIB, 5'h03,  5'h03,  5'h03,  5'h01,  5'h01,  5'h02,  5'h02,
    5'h05,  5'h05,  5'h07,  5'h07,  5'h00,  5'h00,  5'h00,  5'h00,
    5'h04,  5'h05,  5'h06,  5'h06,  5'h04,  5'h04,  5'h06,  NO_NIB,
    NO_NIB, 5'h0B,  5'h0B,  5'h0B,  5'h09,  5'h09,  5'h0A,  5'h09,
    5'h08,  5'h0F,  5'h0F,  5'h0F,  5'h08,  5'h08,  5'h0A,  NO_NIB,
    5'h0D,  5'h0D,  5'h0E,  5'h0E,  5'h0C,  5'h0C,  5'h0A,  NO_NIB,
    5'h0D,  5'h0D,  5'h0E,  NO_NIB, 5'h0C,  NO_NIB, NO_NIB, NO_NIB
};
localparam logic [3:0] BAD_HIGH  = 4'hF;
localparam logic [7:0] BAD_BYTE  = 8'hFF;
localparam int         PRINT_CAP = 40;

// Tracks the group phase and the held byte on the coded side, and keeps the
// decoded beats still owed by the block, oldest first.
class decode_book;
    tsd_pkg::decoded_beat_t owed[$];
    tsd_pkg::phase_t        phase;
    logic [7:0]             last_byte;
    int                     errors;

    function new();
        phase     = tsd_pkg::PH_0;
        last_byte = '0;
        errors    = 0;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    // Map a pair of symbols to one decoded beat.
    function tsd_pkg::decoded_beat_t pair_to_byte(logic [5:0] first, logic [5:0] second);
        logic [4:0]             hi;
        logic [4:0]             lo;
        tsd_pkg::decoded_beat_t r;
        hi = CODE_TO_NIBBLE[first];
        lo = CODE_TO_NIBBLE[second];
        r.symbol_error = hi[MISS_BIT] | lo[MISS_BIT];
        if (lo[MISS_BIT])
        begin
            r.decoded_byte = BAD_BYTE;
        end
        else
        begin
            r.decoded_byte = {(hi[MISS_BIT] ? BAD_HIGH : hi[3:0]), lo[3:0]};
        end
        return r;
    endfunction

    // Advance the group state by one accepted coded beat.
    function void note_coded(tsd_pkg::coded_beat_t beat);
        logic [7:0] b;
        b = beat.coded_byte;
        if (beat.frame_start)
        begin
            phase = tsd_pkg::PH_0;
        end
        case (phase)
            tsd_pkg::PH_1:
            begin
                owed.push_back(pair_to_byte(last_byte[7:2], {last_byte[1:0], b[7:4]}));
                phase = tsd_pkg::PH_2;
            end
            tsd_pkg::PH_2:
            begin
                owed.push_back(pair_to_byte({last_byte[3:0], b[7:6]}, b[5:0]));
                phase = tsd_pkg::PH_0;
            end
            default:
            begin
                phase = tsd_pkg::PH_1;
            end
        endcase
        last_byte = b;
    endfunction

    task report_mismatch(string what, int got, int want);
        if (errors < PRINT_CAP)
        begin
            $display("%0t ns: mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    task check_decoded(tsd_pkg::decoded_beat_t got);
        tsd_pkg::decoded_beat_t want;
        if (owed.size() == 0)
        begin
            report_mismatch("unexpected decoded beat", int'(got), 0);
            return;
        end
        want = owed.pop_front();
        if (got.decoded_byte !== want.decoded_byte)
        begin
            report_mismatch("decoded_byte", int'(got.decoded_byte),
                            int'(want.decoded_byte));
        end
        if (got.symbol_error !== want.symbol_error)
        begin
            report_mismatch("symbol_error", int'(got.symbol_error),
                            int'(want.symbol_error));
        end
    endtask
endclass

module three_of_six_decoder_test;

    // Watchdog: cycles with no beat on either side before the run is called hung.
    // The long receiver hold is well below this.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles to linger after the last owed beat, to catch stray results.
    localparam int DRAIN_CYCLES = 8;
    // Length of the deliberate receiver hold that backs up the block.
    localparam int LONG_HOLD    = 80;
    // Percentage of groups symbols that are drawn from the unmapped codes.
    localparam int BAD_SYM_PCT  = 8;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   coded_valid;
    logic                   coded_ready;
    tsd_pkg::coded_beat_t   coded;
    logic                   decoded_valid;
    logic                   decoded_ready;
    tsd_pkg::decoded_beat_t decoded;

    decode_book    book;
    int            beats_sent    = 0;
    int            send_idle_pct = 0;
    int            take_idle_pct = 0;
    int            hold_request  = 0;
    int            quiet_cycles  = 0;

    three_of_six_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .coded_valid   (coded_valid),
        .coded_ready   (coded_ready),
        .coded         (coded),
        .decoded_valid (decoded_valid),
        .decoded_ready (decoded_ready),
        .decoded       (decoded)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one coded beat, idling first at the current sender rate, and hold
    // it until the block takes it. Handshake values are read right at the edge,
    // before the block's own updates land.
    task automatic send_beat(input logic [7:0] value, input logic fs);
        tsd_pkg::coded_beat_t beat;
        beat.coded_byte  = value;
        beat.frame_start = fs;
        while ($urandom_range(99) < send_idle_pct)
        begin
            coded_valid <= 1'b0;
            @(posedge clk);
        end
        coded_valid <= 1'b1;
        coded       <= beat;
        do
            @(posedge clk);
        while (!coded_ready);
        book.note_coded(beat);
        beats_sent++;
    endtask

    // Pack four symbols, first one in the top bits, into a group of three beats.
    task automatic send_symbols(input logic fs, input logic [5:0] s0, input logic [5:0] s1,
                                input logic [5:0] s2, input logic [5:0] s3);
        logic [23:0] word;
        word = {s0, s1, s2, s3};
        send_beat(word[23:16], fs);
        send_beat(word[15:8], 1'b0);
        send_beat(word[7:0], 1'b0);
    endtask

    // Draw a code that either has or lacks a nibble.
    function automatic logic [5:0] pick_symbol(input logic usable);
        logic [5:0] code;
        do
            code = 6'($urandom_range(63));
        while (CODE_TO_NIBBLE[code][MISS_BIT] == usable);
        return code;
    endfunction

    task automatic send_group(input logic fs);
        send_symbols(fs, pick_symbol($urandom_range(99) >= BAD_SYM_PCT),
                     pick_symbol($urandom_range(99) >= BAD_SYM_PCT),
                     pick_symbol($urandom_range(99) >= BAD_SYM_PCT),
                     pick_symbol($urandom_range(99) >= BAD_SYM_PCT));
    endtask

    // Mostly whole frames with random symbols; the rest are groups cut short
    // by the next frame start, and raw noise with stray frame starts.
    task automatic send_random_until(input int target);
        int kind;
        int n;
        while (beats_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                n = $urandom_range(5, 1);
                send_group(1'b1);
                repeat (n - 1) send_group(1'b0);
            end
            else if (kind < 85)
            begin
                n = $urandom_range(2, 1);
                send_beat(8'($urandom_range(255)), 1'b1);
                if (n == 2)
                begin
                    send_beat(8'($urandom_range(255)), 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(6, 1);
                repeat (n) send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
        end
    endtask

    // Receiver: check each decoded beat as it is taken, then pick ready for the
    // next cycle. A hold request drops ready for a long run so the block backs up
    // and stalls its coded side.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        decoded_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && decoded_valid && decoded_ready)
            begin
                book.check_decoded(decoded);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                decoded_ready <= 1'b0;
            end
            else if (hold_request > 0)
            begin
                hold_left    = hold_request - 1;
                hold_request = 0;
                decoded_ready <= 1'b0;
            end
            else
            begin
                decoded_ready <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    // Watchdog: count cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((coded_valid && coded_ready) || (decoded_valid && decoded_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("three_of_six_decoder_test: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        book = new();
        rst_n       <= 1'b0;
        coded_valid <= 1'b0;
        coded       <= '0;
        send_idle_pct = 29;
        take_idle_pct = 63;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // All four symbols valid.
        send_symbols(1'b1, 6'h16, 6'h0B, 6'h34, 6'h29);
        // Unmapped first symbol in both pairs: high nibble forced to F.
        send_symbols(1'b0, 6'h00, 6'h0D, 6'h3F, 6'h25);
        // Unmapped second symbol in both pairs: whole byte forced to FF.
        send_symbols(1'b0, 6'h07, 6'h1F, 6'h22, 6'h2F);
        // Both symbols unmapped.
        send_symbols(1'b0, 6'h3E, 6'h3D, 6'h20, 6'h08);
        // Extremes of the byte, frame start on a group boundary.
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        // Frame start after two bytes of a group: drop the partial group.
        send_beat(8'hA5, 1'b1);
        send_beat(8'h5A, 1'b0);
        send_symbols(1'b1, 6'h0C, 6'h2A, 6'h31, 6'h1A);
        // Frame start after one byte of a group.
        send_beat(8'h3C, 1'b1);
        send_symbols(1'b1, 6'h38, 6'h13, 6'h03, 6'h1B);

        // Random part: sender idles less than the receiver.
        send_random_until(367);

        // Swap the idle rates.
        send_idle_pct = 63;
        take_idle_pct = 29;
        send_random_until(709);

        // No idling, opened by a long receiver hold while beats keep coming.
        send_idle_pct = 0;
        take_idle_pct = 0;
        hold_request  = LONG_HOLD;
        send_random_until(1050);
        coded_valid <= 1'b0;

        // Drain: wait for every owed beat, then linger for stray results.
        while (book.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0 && book.pending() == 0)
        begin
            $display("three_of_six_decoder_test: PASS");
        end
        else
        begin
            $display("three_of_six_decoder_test: FAIL");
        end
        $finish;
    end

endmodule
